// ----- src/rgb_to_irgb_ordered_dither_assert.svh -----
// Assertion macros shared by the dither block.
`ifndef RGB_TO_IRGB_ORDERED_DITHER_ASSERT_SVH
`define RGB_TO_IRGB_ORDERED_DITHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RGBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RGBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbd assertion failed");

`endif

// ----- src/rgbd_pkg.sv -----
package rgbd_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned OFS_W   = 4;
  localparam int unsigned PIX_W   = 4;
  localparam int unsigned PLANE_W = 16;
  localparam int unsigned QUOT_W  = 4;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned DIVR_W  = 9;
  localparam int unsigned SUM_W   = 10;

  localparam logic [SUM_W-1:0]  GREY_LIMIT  = 10'd8;
  localparam logic [DIVR_W-1:0] DIVR_OFFSET = 9'd8;
  localparam logic [PIX_W-1:0]  CLR_LIGHT_GREY = 4'h7;
  localparam logic [PIX_W-1:0]  CLR_DARK_GREY  = 4'h8;
  localparam logic [PIX_W-1:0]  CLR_BLACK      = 4'h0;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PLANE_W-1:0] plane_t;

  typedef enum logic [1:0] {
    CLS_BRIGHT,
    CLS_LIGHT_GREY,
    CLS_DARK_GREY,
    CLS_COLOR
  } cls_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    chan_t             lum;
    cls_t              cls;
    logic [OFS_W-1:0]  ofs;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Dither pattern table used for dim colors and greys.
  function automatic plane_t dim_plane(input logic [3:0] idx);
    plane_t p;
    case (idx)
      4'd0:    p = 16'h0000;
      4'd1:    p = 16'h8000;
      4'd2:    p = 16'h8020;
      4'd3:    p = 16'h80A0;
      4'd4:    p = 16'hA0A0;
      4'd5:    p = 16'hA4A0;
      4'd6:    p = 16'hA4A1;
      4'd7:    p = 16'hA4A5;
      4'd8:    p = 16'hA5A5;
      4'd9:    p = 16'hADA5;
      4'd10:   p = 16'hADA7;
      4'd11:   p = 16'hADAF;
      4'd12:   p = 16'hAFAF;
      4'd13:   p = 16'hEFAF;
      4'd14:   p = 16'hEFBF;
      4'd15:   p = 16'hEFFF;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Bright table: same as the dim one except that the last entry is solid.
  function automatic plane_t lit_plane(input logic [3:0] idx);
    plane_t p;
    if (idx == 4'd15) begin
      p = 16'hFFFF;
    end else begin
      p = dim_plane(idx);
    end
    return p;
  endfunction

endpackage

// ----- src/rgbd_in_if.sv -----
interface rgbd_in_if;
  logic                             valid;
  logic                             ready;
  logic [rgbd_pkg::CHAN_W-1:0]      red_in;
  logic [rgbd_pkg::CHAN_W-1:0]      green_in;
  logic [rgbd_pkg::CHAN_W-1:0]      blue_in;
  logic [rgbd_pkg::PHASE_W-1:0]     col_phase;
  logic [rgbd_pkg::PHASE_W-1:0]     row_phase;

  modport source (output valid, red_in, green_in, blue_in, col_phase, row_phase,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, col_phase, row_phase,
                output ready);
endinterface

// ----- src/rgbd_out_if.sv -----
interface rgbd_out_if;
  logic                             valid;
  logic                             ready;
  logic [rgbd_pkg::PIX_W-1:0]       dithered_pixel;
  logic [rgbd_pkg::PIX_W-1:0]       solid_color;
  logic [rgbd_pkg::PLANE_W-1:0]     bright_plane;
  logic [rgbd_pkg::PLANE_W-1:0]     red_pattern;
  logic [rgbd_pkg::PLANE_W-1:0]     green_plane;
  logic [rgbd_pkg::PLANE_W-1:0]     blue_plane;

  modport source (output valid, dithered_pixel, solid_color, bright_plane, red_pattern,
                  green_plane, blue_plane, input ready);
  modport sink (input valid, dithered_pixel, solid_color, bright_plane, red_pattern,
                green_plane, blue_plane, output ready);
endinterface

// ----- src/rgb_to_irgb_ordered_dither.sv -----
// RGB to IRGB converter with a 4x4 ordered dither. Each request carries an 8-bit
// RGB color and the pixel's column and row phase; the result gives the four
// 16-bit plane patterns (intensity, red, green, blue), the closest solid IRGB
// color and the dithered IRGB pixel at that phase. The block takes one request
// per clock and gives one result per clock when the sink keeps ready high.
// Each accepted request passes the classification register, the queue, four
// stages of the channel scaling divider (one quotient bit each) and the
// output register. The pipelined divider holds most of these registers; the
// queue between the classification front and the divider back adds a register
// even when it is empty and absorbs short stalls on the result side.
`include "rgb_to_irgb_ordered_dither_assert.svh"

module rgb_to_irgb_ordered_dither #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  rgbd_in_if.sink     in_chan,
  rgbd_out_if.source  out_chan
);

  // Classified request handed from the front to the queue.
  logic                   push_valid;
  logic                   push_ready;
  rgbd_pkg::item_t        push_item;

  // Head of the queue as seen by the back.
  logic                   pop_valid;
  logic                   pop_ack;
  rgbd_pkg::item_t        pop_item;
  rgbd_pkg::q_status_t    q_status;

  // The front finds the maximum channel and sorts the color into bright,
  // light grey, dark grey or plain color.
  rgbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // A short queue decouples the front from the back so that each side can
  // stall without holding the other one.
  rgbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ack    (pop_ack),
    .pop_item   (pop_item),
    .status     (q_status)
  );

  // The back scales the channels of bright colors by 16/(max+8), reads the
  // dither tables and picks the pixel at the requested phase.
  rgbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ack    (pop_ack),
    .pop_item   (pop_item),
    .out_chan   (out_chan)
  );

  // A waiting result must freeze the back, so nothing may leave the queue.
  `RGBD_ASSERT_NOW(a_stall_blocks_pop, clk, rst_n, out_chan.valid && !out_chan.ready, !pop_ack)
  // The back only takes a request that the queue really holds.
  `RGBD_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop_ack, !q_status.empty)
  // A full queue with a request waiting in front must hold off the source.
  `RGBD_ASSERT_NOW(a_full_backpressure, clk, rst_n, q_status.full && push_valid, !in_chan.ready)
  // A full queue that is not drained stays occupied in the next cycle.
  `RGBD_ASSERT_NEXT(a_full_stays, clk, rst_n, q_status.full && !pop_ack, !q_status.empty)

endmodule

// ----- src/rgbd_front.sv -----
module rgbd_front (
  input  logic              clk,
  input  logic              rst_n,
  rgbd_in_if.sink           in_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output rgbd_pkg::item_t   push_item
);

  logic                          valid_r;
  logic                          valid_nxt;
  rgbd_pkg::item_t               item_r;
  rgbd_pkg::item_t               item_nxt;
  rgbd_pkg::chan_t               lum;
  logic [rgbd_pkg::SUM_W-1:0]    grey_dist;
  logic                          accept;

  assign in_chan.ready = !valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    lum = in_chan.red_in;
    if (in_chan.green_in > lum) begin
      lum = in_chan.green_in;
    end
    if (in_chan.blue_in > lum) begin
      lum = in_chan.blue_in;
    end
    // Each term lum - channel is non-negative, so the sum cannot wrap.
    grey_dist = (rgbd_pkg::SUM_W'(lum) << 1) + rgbd_pkg::SUM_W'(lum)
              - rgbd_pkg::SUM_W'(in_chan.red_in)
              - rgbd_pkg::SUM_W'(in_chan.green_in)
              - rgbd_pkg::SUM_W'(in_chan.blue_in);

    item_nxt.red   = in_chan.red_in;
    item_nxt.green = in_chan.green_in;
    item_nxt.blue  = in_chan.blue_in;
    item_nxt.lum   = lum;
    item_nxt.ofs   = {in_chan.row_phase, in_chan.col_phase};
    if (lum[rgbd_pkg::CHAN_W-1]) begin
      item_nxt.cls = rgbd_pkg::CLS_BRIGHT;
    end else if (grey_dist < rgbd_pkg::GREY_LIMIT) begin
      item_nxt.cls = lum[6] ? rgbd_pkg::CLS_LIGHT_GREY : rgbd_pkg::CLS_DARK_GREY;
    end else begin
      item_nxt.cls = rgbd_pkg::CLS_COLOR;
    end

    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// ----- src/rgbd_queue.sv -----
module rgbd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  rgbd_pkg::item_t        push_item,
  output logic                   pop_valid,
  input  logic                   pop_ack,
  output rgbd_pkg::item_t        pop_item,
  output rgbd_pkg::q_status_t    status
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rgbd_pkg::item_t     mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                push;
  logic                pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign push         = push_valid && push_ready;
  assign pop          = pop_ack && pop_valid;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers wrap at the last entry so that depths other than powers of two work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/rgbd_back.sv -----
module rgbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ack,
  input  rgbd_pkg::item_t   pop_item,
  rgbd_out_if.source        out_chan
);

  localparam int unsigned NSTG  = rgbd_pkg::QUOT_W;
  localparam int unsigned NCHAN = 3;

  typedef struct packed {
    rgbd_pkg::item_t                                item;
    logic [NCHAN-1:0][rgbd_pkg::REM_W-1:0]          rem;
    logic [NCHAN-1:0][rgbd_pkg::QUOT_W-1:0]         quot;
  } div_stage_t;

  div_stage_t                      stg_r   [NSTG];
  div_stage_t                      stg_nxt [NSTG];
  logic [NSTG-1:0]                 vld_r;
  logic                            adv;

  logic                            out_valid_r;
  logic [rgbd_pkg::PIX_W-1:0]      pix_r,   pix_nxt;
  logic [rgbd_pkg::PIX_W-1:0]      clr_r,   clr_nxt;
  rgbd_pkg::plane_t                pi_r,    pi_nxt;
  rgbd_pkg::plane_t                pr_r,    pr_nxt;
  rgbd_pkg::plane_t                pg_r,    pg_nxt;
  rgbd_pkg::plane_t                pb_r,    pb_nxt;

  // The whole back pipeline moves together and holds while the result waits.
  assign adv     = !out_valid_r || out_chan.ready;
  assign pop_ack = adv && pop_valid;

  // Restoring division of channel*16 by lum+8, one quotient bit per stage.
  // Since channel <= lum, the quotient always fits in four bits.
  always_comb begin
    div_stage_t                    src;
    logic [rgbd_pkg::REM_W-1:0]    dsh;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        src.item    = pop_item;
        src.rem[0]  = {pop_item.red,   4'b0000};
        src.rem[1]  = {pop_item.green, 4'b0000};
        src.rem[2]  = {pop_item.blue,  4'b0000};
        src.quot    = '0;
      end else begin
        src = stg_r[s-1];
      end
      dsh = rgbd_pkg::REM_W'({1'b0, src.item.lum} + rgbd_pkg::DIVR_OFFSET)
            << (NSTG - 1 - s);
      stg_nxt[s] = src;
      for (int c = 0; c < NCHAN; c++) begin
        if (src.rem[c] >= dsh) begin
          stg_nxt[s].rem[c]               = src.rem[c] - dsh;
          stg_nxt[s].quot[c][NSTG - 1 - s] = 1'b1;
        end
      end
    end
  end

  // Table lookup and pixel select on the last division stage.
  always_comb begin
    div_stage_t       fin;
    rgbd_pkg::plane_t grey;
    fin  = stg_r[NSTG-1];
    grey = rgbd_pkg::dim_plane(fin.item.lum[5:2]);
    case (fin.item.cls)
      rgbd_pkg::CLS_BRIGHT: begin
        pi_nxt  = rgbd_pkg::lit_plane(fin.item.lum[6:3]);
        pr_nxt  = rgbd_pkg::lit_plane(fin.quot[0]);
        pg_nxt  = rgbd_pkg::lit_plane(fin.quot[1]);
        pb_nxt  = rgbd_pkg::lit_plane(fin.quot[2]);
        clr_nxt = {1'b1, fin.item.red[7], fin.item.green[7], fin.item.blue[7]};
      end
      rgbd_pkg::CLS_LIGHT_GREY: begin
        pi_nxt  = ~grey;
        pr_nxt  = grey;
        pg_nxt  = grey;
        pb_nxt  = grey;
        clr_nxt = rgbd_pkg::CLR_LIGHT_GREY;
      end
      rgbd_pkg::CLS_DARK_GREY: begin
        pi_nxt  = grey;
        pr_nxt  = '0;
        pg_nxt  = '0;
        pb_nxt  = '0;
        clr_nxt = fin.item.lum[5] ? rgbd_pkg::CLR_DARK_GREY : rgbd_pkg::CLR_BLACK;
      end
      default: begin
        pi_nxt  = '0;
        pr_nxt  = rgbd_pkg::dim_plane(fin.item.red[6:3]);
        pg_nxt  = rgbd_pkg::dim_plane(fin.item.green[6:3]);
        pb_nxt  = rgbd_pkg::dim_plane(fin.item.blue[6:3]);
        clr_nxt = {1'b0, fin.item.red[6], fin.item.green[6], fin.item.blue[6]};
      end
    endcase
    pix_nxt = {pi_nxt[fin.item.ofs], pr_nxt[fin.item.ofs],
               pg_nxt[fin.item.ofs], pb_nxt[fin.item.ofs]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], pop_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSTG; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
      pix_r <= pix_nxt;
      clr_r <= clr_nxt;
      pi_r  <= pi_nxt;
      pr_r  <= pr_nxt;
      pg_r  <= pg_nxt;
      pb_r  <= pb_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.dithered_pixel = pix_r;
  assign out_chan.solid_color    = clr_r;
  assign out_chan.bright_plane   = pi_r;
  assign out_chan.red_pattern    = pr_r;
  assign out_chan.green_plane    = pg_r;
  assign out_chan.blue_plane     = pb_r;

endmodule
